@@ hdl/rpi_pkg.sv @@
// Package for the ray against polygon intersection block.
// Holds the widths, the channel item types, the sequencer states and the divider status.
// Used by every other file of the block; it depends on nothing.
package rpi_pkg;

   localparam int COORD_WIDTH = 32;
   localparam int FRAC_BITS   = 16;
   localparam int DIFF_W      = COORD_WIDTH + 1;
   localparam int MUL_W       = DIFF_W;
   localparam int PROD_W      = 2 * MUL_W;
   localparam int CR_W        = PROD_W - FRAC_BITS + 2;
   localparam int NUM_W       = CR_W + FRAC_BITS;
   localparam int CNT_W       = $clog2(NUM_W + 1);
   localparam int T_W         = FRAC_BITS + 1;
   localparam int DIST_W      = 63;
   localparam logic [NUM_W-1:0] ONE_Q = NUM_W'(1) << FRAC_BITS;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] ray_start_x;
      logic signed [COORD_WIDTH-1:0] ray_start_y;
      logic signed [COORD_WIDTH-1:0] ray_cast_x;
      logic signed [COORD_WIDTH-1:0] ray_cast_y;
      logic signed [COORD_WIDTH-1:0] vertex_x;
      logic signed [COORD_WIDTH-1:0] vertex_y;
      logic                          last_vertex;
   } req_type;

   typedef struct packed {
      logic                          hit;
      logic signed [COORD_WIDTH-1:0] point_x;
      logic signed [COORD_WIDTH-1:0] point_y;
      logic signed [COORD_WIDTH-1:0] normal_x;
      logic signed [COORD_WIDTH-1:0] normal_y;
      logic [DIST_W-1:0]             sq_distance;
   } rsp_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_EDGE,
      ST_M_DEN1,
      ST_M_DEN2,
      ST_CHK_DEN,
      ST_M_U1,
      ST_M_U2,
      ST_DIVU_GO,
      ST_DIVU_WAIT,
      ST_M_T1,
      ST_M_T2,
      ST_DIVT_GO,
      ST_DIVT_WAIT,
      ST_M_DX,
      ST_M_DY,
      ST_M_DXX,
      ST_M_DYY,
      ST_UPDATE,
      ST_NEXT,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic             done;
      logic             neg;
      logic [NUM_W-1:0] mag;
   } div_type;

endpackage

@@ hdl/ray_polygon_intersect.sv @@
// Top level of the ray against polygon intersection block: sequencer and datapath.
// Depends on rpi_pkg, rpi_mul and rpi_div.
//
// Usage: one item on the req channel carries one polygon vertex; the ray start and
// cast vector are taken from the first vertex of a polygon and ignored afterwards.
// The item flagged last_vertex closes the polygon and produces one item on the rsp
// channel with the hit flag, nearest point, unnormalized edge normal and squared
// distance (all zero when nothing was hit).
// Each edge is tested on one shared multiplier and one shared divider that yields a
// quotient bit per cycle. A vertex that forms no edge only has its data stored. An
// edge ends after the denominator test when the ray is parallel to it, and otherwise
// runs up to two divisions; the last vertex of a polygon of two or more vertices runs its
// edge and the closing edge, then loads the result once the output register is free.
// req_stall is high while an edge is being worked on and while the result is loaded.
// The result sits in an output register, so the next polygon can start while the
// receiver stalls; only a following last vertex waits for that register to empty.
// Synchronous reset returns the block to the start of a new polygon, with no result
// pending.
module ray_polygon_intersect (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  rpi_pkg::req_type req_item,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rpi_pkg::rsp_type rsp_item
);

   localparam int CW = rpi_pkg::COORD_WIDTH;
   localparam int DW = rpi_pkg::DIFF_W;

   rpi_pkg::state_type state_ff, state_in;

   logic                                in_poly_ff;
   logic                                found_ff;
   logic                                closing_ff;
   logic                                pend_ff;
   logic                                rsp_valid_ff;
   rpi_pkg::rsp_type                    rsp_ff;
   logic signed [CW-1:0]                sx_ff, sy_ff, cx_ff, cy_ff;
   logic signed [CW-1:0]                first_x_ff, first_y_ff, prev_x_ff, prev_y_ff;
   logic signed [CW-1:0]                cur_x_ff, cur_y_ff;
   logic signed [CW-1:0]                from_x_ff, from_y_ff, to_x_ff, to_y_ff;
   logic signed [DW-1:0]                ex_ff, ey_ff, wx_ff, wy_ff;
   logic signed [rpi_pkg::CR_W-1:0]     acc_ff, den_ff;
   logic [rpi_pkg::T_W-1:0]             t_ff;
   logic signed [rpi_pkg::MUL_W-1:0]    dx_ff, dy_ff;
   logic signed [CW-1:0]                best_px_ff, best_py_ff, best_ex_ff, best_ey_ff;
   logic [rpi_pkg::DIST_W-1:0]          best_dist_ff;

   logic signed [rpi_pkg::MUL_W-1:0]    mul_a, mul_b;
   logic signed [rpi_pkg::PROD_W-1:0]   prod, prod_sh;
   logic signed [rpi_pkg::CR_W-1:0]     prod_lo, crs;
   logic [rpi_pkg::CR_W-1:0]            dsum;
   logic [rpi_pkg::DIST_W-1:0]          sq_dist;
   logic                                div_start;
   logic signed [rpi_pkg::NUM_W-1:0]    div_num;
   rpi_pkg::div_type                    div_res;
   logic                                div_fail;
   logic                                accept;
   logic                                slot_free;
   logic                                take;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != rpi_pkg::ST_IDLE);
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   assign prod_sh = prod >>> rpi_pkg::FRAC_BITS;
   assign prod_lo = prod_sh[rpi_pkg::CR_W-1:0];
   assign crs     = acc_ff - prod_lo;
   assign div_num = {crs, {rpi_pkg::FRAC_BITS{1'b0}}};
   assign dsum    = acc_ff + prod_lo;
   assign sq_dist = {{(rpi_pkg::DIST_W - rpi_pkg::CR_W){1'b0}}, dsum};
   assign div_fail = (div_res.neg && (div_res.mag != '0)) || (div_res.mag > rpi_pkg::ONE_Q);
   assign take    = !found_ff || (sq_dist < best_dist_ff)
                 || (closing_ff && sq_dist == best_dist_ff);

   rpi_mul u_mul (
      .clock (clock),
      .a     (mul_a),
      .b     (mul_b),
      .prod  (prod)
   );

   rpi_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (den_ff),
      .res   (div_res)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rpi_pkg::ST_IDLE: begin
            if (accept && (in_poly_ff || req_item.last_vertex)) begin
               state_in = rpi_pkg::ST_EDGE;
            end
         end
         rpi_pkg::ST_EDGE:    state_in = rpi_pkg::ST_M_DEN1;
         rpi_pkg::ST_M_DEN1:  state_in = rpi_pkg::ST_M_DEN2;
         rpi_pkg::ST_M_DEN2:  state_in = rpi_pkg::ST_CHK_DEN;
         rpi_pkg::ST_CHK_DEN: state_in = (crs == '0) ? rpi_pkg::ST_NEXT : rpi_pkg::ST_M_U1;
         rpi_pkg::ST_M_U1:    state_in = rpi_pkg::ST_M_U2;
         rpi_pkg::ST_M_U2:    state_in = rpi_pkg::ST_DIVU_GO;
         rpi_pkg::ST_DIVU_GO: state_in = rpi_pkg::ST_DIVU_WAIT;
         rpi_pkg::ST_DIVU_WAIT: begin
            if (div_res.done) begin
               state_in = div_fail ? rpi_pkg::ST_NEXT : rpi_pkg::ST_M_T1;
            end
         end
         rpi_pkg::ST_M_T1:    state_in = rpi_pkg::ST_M_T2;
         rpi_pkg::ST_M_T2:    state_in = rpi_pkg::ST_DIVT_GO;
         rpi_pkg::ST_DIVT_GO: state_in = rpi_pkg::ST_DIVT_WAIT;
         rpi_pkg::ST_DIVT_WAIT: begin
            if (div_res.done) begin
               state_in = div_fail ? rpi_pkg::ST_NEXT : rpi_pkg::ST_M_DX;
            end
         end
         rpi_pkg::ST_M_DX:    state_in = rpi_pkg::ST_M_DY;
         rpi_pkg::ST_M_DY:    state_in = rpi_pkg::ST_M_DXX;
         rpi_pkg::ST_M_DXX:   state_in = rpi_pkg::ST_M_DYY;
         rpi_pkg::ST_M_DYY:   state_in = rpi_pkg::ST_UPDATE;
         rpi_pkg::ST_UPDATE:  state_in = rpi_pkg::ST_NEXT;
         rpi_pkg::ST_NEXT: begin
            if (closing_ff) begin
               state_in = rpi_pkg::ST_OUT;
            end else if (pend_ff) begin
               state_in = rpi_pkg::ST_EDGE;
            end else begin
               state_in = rpi_pkg::ST_IDLE;
            end
         end
         rpi_pkg::ST_OUT: begin
            if (slot_free) begin
               state_in = rpi_pkg::ST_IDLE;
            end
         end
         default: state_in = rpi_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      mul_a     = '0;
      mul_b     = '0;
      div_start = 1'b0;
      case (state_ff)
         rpi_pkg::ST_M_DEN1: begin
            mul_a = DW'(cx_ff);
            mul_b = ey_ff;
         end
         rpi_pkg::ST_M_DEN2: begin
            mul_a = DW'(cy_ff);
            mul_b = ex_ff;
         end
         rpi_pkg::ST_M_U1: begin
            mul_a = wx_ff;
            mul_b = DW'(cy_ff);
         end
         rpi_pkg::ST_M_U2: begin
            mul_a = wy_ff;
            mul_b = DW'(cx_ff);
         end
         rpi_pkg::ST_M_T1: begin
            mul_a = wx_ff;
            mul_b = ey_ff;
         end
         rpi_pkg::ST_M_T2: begin
            mul_a = wy_ff;
            mul_b = ex_ff;
         end
         rpi_pkg::ST_M_DX: begin
            mul_a = DW'(cx_ff);
            mul_b = {{(rpi_pkg::MUL_W - rpi_pkg::T_W){1'b0}}, t_ff};
         end
         rpi_pkg::ST_M_DY: begin
            mul_a = DW'(cy_ff);
            mul_b = {{(rpi_pkg::MUL_W - rpi_pkg::T_W){1'b0}}, t_ff};
         end
         rpi_pkg::ST_M_DXX: begin
            mul_a = dx_ff;
            mul_b = dx_ff;
         end
         rpi_pkg::ST_M_DYY: begin
            mul_a = dy_ff;
            mul_b = dy_ff;
         end
         rpi_pkg::ST_DIVU_GO,
         rpi_pkg::ST_DIVT_GO: begin
            div_start = 1'b1;
         end
         default: begin
            div_start = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rpi_pkg::ST_IDLE;
         in_poly_ff   <= 1'b0;
         found_ff     <= 1'b0;
         closing_ff   <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == rpi_pkg::ST_OUT && slot_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            rpi_pkg::ST_IDLE: begin
               if (accept) begin
                  if (!in_poly_ff) begin
                     in_poly_ff <= 1'b1;
                     found_ff   <= 1'b0;
                     closing_ff <= 1'b1;
                     pend_ff    <= 1'b0;
                  end else begin
                     closing_ff <= 1'b0;
                     pend_ff    <= req_item.last_vertex;
                  end
               end
            end
            rpi_pkg::ST_UPDATE: begin
               found_ff <= 1'b1;
            end
            rpi_pkg::ST_NEXT: begin
               if (!closing_ff && pend_ff) begin
                  closing_ff <= 1'b1;
                  pend_ff    <= 1'b0;
               end
            end
            rpi_pkg::ST_OUT: begin
               if (slot_free) begin
                  in_poly_ff   <= 1'b0;
                  found_ff     <= 1'b0;
               end
            end
            default: begin
               found_ff <= found_ff;
            end
         endcase
      end

      case (state_ff)
         rpi_pkg::ST_IDLE: begin
            if (accept) begin
               prev_x_ff <= req_item.vertex_x;
               prev_y_ff <= req_item.vertex_y;
               cur_x_ff  <= req_item.vertex_x;
               cur_y_ff  <= req_item.vertex_y;
               to_x_ff   <= req_item.vertex_x;
               to_y_ff   <= req_item.vertex_y;
               if (!in_poly_ff) begin
                  sx_ff      <= req_item.ray_start_x;
                  sy_ff      <= req_item.ray_start_y;
                  cx_ff      <= req_item.ray_cast_x;
                  cy_ff      <= req_item.ray_cast_y;
                  first_x_ff <= req_item.vertex_x;
                  first_y_ff <= req_item.vertex_y;
                  from_x_ff  <= req_item.vertex_x;
                  from_y_ff  <= req_item.vertex_y;
               end else begin
                  from_x_ff <= prev_x_ff;
                  from_y_ff <= prev_y_ff;
               end
            end
         end
         rpi_pkg::ST_EDGE: begin
            ex_ff <= DW'(to_x_ff) - DW'(from_x_ff);
            ey_ff <= DW'(to_y_ff) - DW'(from_y_ff);
            wx_ff <= DW'(from_x_ff) - DW'(sx_ff);
            wy_ff <= DW'(from_y_ff) - DW'(sy_ff);
         end
         rpi_pkg::ST_M_DEN2,
         rpi_pkg::ST_M_U2,
         rpi_pkg::ST_M_T2,
         rpi_pkg::ST_M_DYY: begin
            acc_ff <= prod_lo;
         end
         rpi_pkg::ST_CHK_DEN: begin
            den_ff <= crs;
         end
         rpi_pkg::ST_DIVT_WAIT: begin
            t_ff <= div_res.mag[rpi_pkg::T_W-1:0];
         end
         rpi_pkg::ST_M_DY: begin
            dx_ff <= prod_sh[rpi_pkg::MUL_W-1:0];
         end
         rpi_pkg::ST_M_DXX: begin
            dy_ff <= prod_sh[rpi_pkg::MUL_W-1:0];
         end
         rpi_pkg::ST_UPDATE: begin
            if (take) begin
               best_dist_ff <= sq_dist;
               best_px_ff   <= sx_ff + dx_ff[CW-1:0];
               best_py_ff   <= sy_ff + dy_ff[CW-1:0];
               best_ex_ff   <= ex_ff[CW-1:0];
               best_ey_ff   <= ey_ff[CW-1:0];
            end
         end
         rpi_pkg::ST_NEXT: begin
            if (!closing_ff && pend_ff) begin
               from_x_ff <= cur_x_ff;
               from_y_ff <= cur_y_ff;
               to_x_ff   <= first_x_ff;
               to_y_ff   <= first_y_ff;
            end
         end
         rpi_pkg::ST_OUT: begin
            if (slot_free) begin
               rsp_ff.hit         <= found_ff;
               rsp_ff.point_x     <= found_ff ? best_px_ff : '0;
               rsp_ff.point_y     <= found_ff ? best_py_ff : '0;
               rsp_ff.normal_x    <= found_ff ? best_ey_ff : '0;
               rsp_ff.normal_y    <= found_ff ? -best_ex_ff : '0;
               rsp_ff.sq_distance <= found_ff ? best_dist_ff : '0;
            end
         end
         default: begin
            t_ff <= t_ff;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   a_out_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rpi_pkg::ST_OUT && slot_free) |=> rsp_valid)
      else $error("result not presented after the output stage");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_item.hit) |-> (rsp_item.sq_distance == '0))
      else $error("miss item carries a distance");

   a_div_done_wait: assert property (@(posedge clock) disable iff (reset)
      div_res.done |-> (state_ff == rpi_pkg::ST_DIVU_WAIT || state_ff == rpi_pkg::ST_DIVT_WAIT))
      else $error("divider finished outside a wait state");

   a_edge_in_poly: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rpi_pkg::ST_EDGE) |-> in_poly_ff)
      else $error("edge tested outside a polygon");

endmodule

@@ hdl/rpi_mul.sv @@
// Shared signed multiplier with a registered product.
// Depends on rpi_pkg for the operand and product widths.
module rpi_mul (
   input  logic                                clock,
   input  logic signed [rpi_pkg::MUL_W-1:0]    a,
   input  logic signed [rpi_pkg::MUL_W-1:0]    b,
   output logic signed [rpi_pkg::PROD_W-1:0]   prod
);

   logic signed [rpi_pkg::PROD_W-1:0] prod_ff;
   logic signed [rpi_pkg::PROD_W-1:0] prod_in;

   assign prod_in = rpi_pkg::PROD_W'(a) * rpi_pkg::PROD_W'(b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

@@ hdl/rpi_div.sv @@
// Iterative restoring divider, one quotient bit per cycle, truncating toward zero.
// Depends on rpi_pkg for widths and the status struct.
module rpi_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic signed [rpi_pkg::NUM_W-1:0]  num,
   input  logic signed [rpi_pkg::CR_W-1:0]   den,
   output rpi_pkg::div_type                  res
);

   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [rpi_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   logic [rpi_pkg::CR_W:0]      rem_ff, rem_in;
   logic [rpi_pkg::NUM_W-1:0]   quo_ff, quo_in;
   logic [rpi_pkg::CR_W-1:0]    dmag_ff, dmag_in;
   logic                        neg_ff, neg_in;
   logic [rpi_pkg::CR_W:0]      rem_sh;
   logic [rpi_pkg::CR_W+1:0]    diff;
   logic                        ge;

   assign rem_sh = {rem_ff[rpi_pkg::CR_W-1:0], quo_ff[rpi_pkg::NUM_W-1]};
   assign diff   = {1'b0, rem_sh} - {2'b00, dmag_ff};
   assign ge     = !diff[rpi_pkg::CR_W+1];

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dmag_in = dmag_ff;
      neg_in  = neg_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = num[rpi_pkg::NUM_W-1] ? -num : num;
         dmag_in = den[rpi_pkg::CR_W-1] ? -den : den;
         neg_in  = num[rpi_pkg::NUM_W-1] ^ den[rpi_pkg::CR_W-1];
      end else if (busy_ff) begin
         rem_in = ge ? diff[rpi_pkg::CR_W:0] : rem_sh;
         quo_in = {quo_ff[rpi_pkg::NUM_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == rpi_pkg::CNT_W'(rpi_pkg::NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dmag_ff <= dmag_in;
      neg_ff  <= neg_in;
   end

   assign res.done = done_ff;
   assign res.neg  = neg_ff;
   assign res.mag  = quo_ff;

endmodule
